### rtl/core/ima4dec_pkg.sv
// shared types, constants and the ima/dvi step arithmetic for the ima4 block decoder
// no dependencies; imported by every module of the block
package ima4dec_pkg;

  localparam int DATA_BYTES = 32;
  localparam int STORE_AW   = $clog2(DATA_BYTES);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam logic [6:0] BLK_BYTES  = 7'(DATA_BYTES + 2);
  localparam logic [6:0] PAIR_BYTES = 7'(2 * (DATA_BYTES + 2));
  localparam logic [6:0] IDX_MAX    = 7'd88;

  // one channel-state operation: header load or one nibble step
  typedef struct packed {
    logic        valid;
    logic        hdr;
    logic        chan;
    logic [3:0]  code;
    logic        last;
    logic [15:0] hdr_pred;
    logic [6:0]  hdr_idx;
  } op_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        chan;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] pred;
    logic [6:0]  idx;
  } chst_t;

  function automatic logic [14:0] step_size(input logic [6:0] idx);
    logic [14:0] s;
    case (idx)
      7'd0: s = 15'd7;       7'd1: s = 15'd8;       7'd2: s = 15'd9;
      7'd3: s = 15'd10;      7'd4: s = 15'd11;      7'd5: s = 15'd12;
      7'd6: s = 15'd13;      7'd7: s = 15'd14;      7'd8: s = 15'd16;
      7'd9: s = 15'd17;      7'd10: s = 15'd19;     7'd11: s = 15'd21;
      7'd12: s = 15'd23;     7'd13: s = 15'd25;     7'd14: s = 15'd28;
      7'd15: s = 15'd31;     7'd16: s = 15'd34;     7'd17: s = 15'd37;
      7'd18: s = 15'd41;     7'd19: s = 15'd45;     7'd20: s = 15'd50;
      7'd21: s = 15'd55;     7'd22: s = 15'd60;     7'd23: s = 15'd66;
      7'd24: s = 15'd73;     7'd25: s = 15'd80;     7'd26: s = 15'd88;
      7'd27: s = 15'd97;     7'd28: s = 15'd107;    7'd29: s = 15'd118;
      7'd30: s = 15'd130;    7'd31: s = 15'd143;    7'd32: s = 15'd157;
      7'd33: s = 15'd173;    7'd34: s = 15'd190;    7'd35: s = 15'd209;
      7'd36: s = 15'd230;    7'd37: s = 15'd253;    7'd38: s = 15'd279;
      7'd39: s = 15'd307;    7'd40: s = 15'd337;    7'd41: s = 15'd371;
      7'd42: s = 15'd408;    7'd43: s = 15'd449;    7'd44: s = 15'd494;
      7'd45: s = 15'd544;    7'd46: s = 15'd598;    7'd47: s = 15'd658;
      7'd48: s = 15'd724;    7'd49: s = 15'd796;    7'd50: s = 15'd876;
      7'd51: s = 15'd963;    7'd52: s = 15'd1060;   7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;   7'd55: s = 15'd1411;   7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;   7'd58: s = 15'd1878;   7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;   7'd61: s = 15'd2499;   7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;   7'd64: s = 15'd3327;   7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;   7'd67: s = 15'd4428;   7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;   7'd70: s = 15'd5894;   7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;   7'd73: s = 15'd7845;   7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;   7'd76: s = 15'd10442;  7'd77: s = 15'd11487;
      7'd78: s = 15'd12635;  7'd79: s = 15'd13899;  7'd80: s = 15'd15289;
      7'd81: s = 15'd16818;  7'd82: s = 15'd18500;  7'd83: s = 15'd20350;
      7'd84: s = 15'd22385;  7'd85: s = 15'd24623;  7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  function automatic chst_t dvi_step(input chst_t cur, input logic [3:0] code);
    logic [14:0]        st;
    logic [16:0]        diff;
    logic signed [17:0] p;
    logic signed [7:0]  i;
    chst_t              r;
    st   = step_size(cur.idx);
    diff = 17'(st >> 3);
    if (code[2]) diff = diff + 17'(st);
    if (code[1]) diff = diff + 17'(st >> 1);
    if (code[0]) diff = diff + 17'(st >> 2);
    p = {{2{cur.pred[15]}}, cur.pred};
    if (code[3]) p = p - $signed({1'b0, diff});
    else         p = p + $signed({1'b0, diff});
    if (p > 18'sd32767)       r.pred = 16'h7fff;
    else if (p < -18'sd32768) r.pred = 16'h8000;
    else                      r.pred = p[15:0];
    i = $signed({1'b0, cur.idx});
    if (code[2]) i = i + $signed({5'b0, code[1:0], 1'b0}) + 8'sd2;
    else         i = i - 8'sd1;
    if (i < 8'sd0)                         r.idx = 7'd0;
    else if (i > $signed({1'b0, IDX_MAX})) r.idx = IDX_MAX;
    else                                   r.idx = i[6:0];
    return r;
  endfunction

endpackage

### rtl/core/ima4dec_chan_unit.sv
// channel state memory (predictor and step index per channel) with read-modify-write
// and forwarding of the previous write; depends on ima4dec_pkg
module ima4dec_chan_unit (
  input  logic               clk,
  input  logic               rst,
  input  ima4dec_pkg::op_t   op_in,
  output ima4dec_pkg::res_t  res,
  output logic               res_valid
);
  import ima4dec_pkg::*;

  chst_t      chan_mem [2];
  logic [1:0] chan_vld;
  chst_t      rd;
  logic       rd_vld;
  op_t        op;
  chst_t      fwd;
  logic       fwd_chan;
  logic       fwd_valid;
  chst_t      cur;
  chst_t      nxt;

  always_ff @(posedge clk) begin
    rd <= chan_mem[op_in.chan];
    if (op.valid) chan_mem[op.chan] <= nxt;
  end

  always_ff @(posedge clk) begin
    fwd      <= nxt;
    fwd_chan <= op.chan;
    if (rst) begin
      op        <= '0;
      chan_vld  <= 2'b00;
      rd_vld    <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      op        <= op_in;
      rd_vld    <= chan_vld[op_in.chan];
      fwd_valid <= op.valid;
      if (op.valid) chan_vld[op.chan] <= 1'b1;
    end
  end

  // the entry written last cycle was read before the write landed
  always_comb begin
    if (fwd_valid && fwd_chan == op.chan) cur = fwd;
    else if (rd_vld)                      cur = rd;
    else                                  cur = '0;
    if (op.hdr) nxt = {op.hdr_pred, op.hdr_idx};
    else        nxt = dvi_step(cur, op.code);
  end

  assign res       = {nxt.pred, op.chan, op.last};
  assign res_valid = op.valid & ~op.hdr;

endmodule

### rtl/core/ima4dec_out_fifo.sv
// small output queue for decoded samples, flip-flop storage
// depends on ima4dec_pkg
module ima4dec_out_fifo (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  ima4dec_pkg::res_t                   push_data,
  input  logic                                pop,
  output ima4dec_pkg::res_t                   head,
  output logic                                not_empty,
  output logic [ima4dec_pkg::FIFO_CW-1:0]     cnt
);
  import ima4dec_pkg::*;

  res_t               fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic               do_pop;

  assign not_empty = (cnt != '0);
  assign head      = fifo_mem[rd_ptr];
  assign do_pop    = pop & not_empty;

  always_ff @(posedge clk) begin
    if (push) fifo_mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push)   wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      cnt <= cnt + FIFO_CW'(push) - FIFO_CW'(do_pop);
    end
  end

endmodule

### rtl/core/ima4_adpcm_block_decoder_unit.sv
// top level of the ima4 adpcm block decoder: byte framing, left byte store, op sequencer
// depends on ima4dec_pkg, ima4dec_chan_unit and ima4dec_out_fifo
//
// Decodes a QuickTime IMA4 byte stream (34-byte blocks: two header bytes, then 32 data
// bytes of 64 nibbles, low nibble first) into signed 16-bit samples, one beat of output
// per clock at most. A header byte or a stereo left-block byte gives no sample; a mono
// data byte yields two samples and a stereo right-block byte yields four (L,R,L,R, the
// left nibbles coming from the stored left byte at the same offset), one op per sample.
// The channel-state memory does one read-modify-write step per cycle; sample ops wait
// while the output queue lacks room, and a new byte can be taken while the last op of
// the previous byte issues. A small output queue lets input carry on while the sink
// stalls. Writing stereo_mode (register 0) restarts block framing and must only be done
// while the block is idle. No clearing pass is needed after reset.
module ima4_adpcm_block_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] sample
  output logic        m_tuser,   // [0] channel
  output logic        m_tlast
);
  import ima4dec_pkg::*;

  localparam logic [1:0] JOB_HDR  = 2'd0;
  localparam logic [1:0] JOB_MONO = 2'd1;
  localparam logic [1:0] JOB_PAIR = 2'd2;

  logic                stereo_mode;
  logic [6:0]          pos;
  logic [7:0]          header_high;
  logic                job_valid;
  logic [1:0]          job_kind;
  logic [1:0]          job_step;
  logic [7:0]          job_byte;
  logic                job_chan;
  logic [15:0]         job_pred;
  logic [6:0]          job_idx;
  logic [7:0]          left_store [DATA_BYTES];
  logic [7:0]          lb_rd;

  logic                cfg_wr;
  logic                in_acc;
  logic [6:0]          limit;
  logic [6:0]          pos_eff;
  logic [6:0]          pos_inc;
  logic [6:0]          pos_next;
  logic                first_blk;
  logic [6:0]          off;
  logic [6:0]          off_m2;
  logic [STORE_AW-1:0] sidx;
  logic                is_hdr_hi;
  logic                is_hdr_lo;
  logic                is_store;
  logic                is_pair;
  logic                load_job;
  logic [1:0]          new_kind;
  logic [6:0]          new_idx;

  logic [1:0]          last_step;
  logic                needs_out;
  logic                credit_ok;
  logic                issue;
  logic                job_done;
  logic [7:0]          src_byte;
  logic                half;
  op_t                 op;

  res_t                res;
  logic                res_valid;
  res_t                head;
  logic [FIFO_CW-1:0]  fifo_cnt;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = paddr[2] ? 32'd0 : {31'd0, stereo_mode};

  // framing of the incoming byte
  assign in_acc    = s_tvalid & s_tready;
  assign limit     = stereo_mode ? PAIR_BYTES : BLK_BYTES;
  assign pos_eff   = (pos >= limit) ? 7'd0 : pos;
  assign pos_inc   = pos_eff + 7'd1;
  assign pos_next  = (pos_inc >= limit) ? 7'd0 : pos_inc;
  assign first_blk = (pos_eff < BLK_BYTES);
  assign off       = first_blk ? pos_eff : pos_eff - BLK_BYTES;
  assign off_m2    = off - 7'd2;
  assign sidx      = off_m2[STORE_AW-1:0];
  assign is_hdr_hi = (off == 7'd0);
  assign is_hdr_lo = (off == 7'd1);
  assign is_store  = ~is_hdr_hi & ~is_hdr_lo & stereo_mode & first_blk;
  assign is_pair   = ~is_hdr_hi & ~is_hdr_lo & stereo_mode & ~first_blk;
  assign load_job  = in_acc & ~is_hdr_hi & ~is_store;
  assign new_kind  = is_hdr_lo ? JOB_HDR : (is_pair ? JOB_PAIR : JOB_MONO);
  assign new_idx   = (s_tdata[6:0] > IDX_MAX) ? IDX_MAX : s_tdata[6:0];

  always_ff @(posedge clk) begin
    if (in_acc && is_store) left_store[sidx] <= s_tdata;
    if (in_acc && is_pair)  lb_rd <= left_store[sidx];
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_hdr_hi) header_high <= s_tdata;
    if (load_job) begin
      job_kind <= new_kind;
      job_byte <= s_tdata;
      job_chan <= ~first_blk;
      job_pred <= {header_high, s_tdata[7], 7'd0};
      job_idx  <= new_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_mode <= 1'b0;
      pos         <= 7'd0;
      job_valid   <= 1'b0;
      job_step    <= 2'd0;
    end else begin
      if (cfg_wr && !paddr[2]) begin
        stereo_mode <= pwdata[0];
        pos         <= 7'd0;
      end else if (in_acc) begin
        pos <= pos_next;
      end
      if (load_job) begin
        job_valid <= 1'b1;
        job_step  <= 2'd0;
      end else if (job_done) begin
        job_valid <= 1'b0;
      end else if (issue) begin
        job_step <= job_step + 2'd1;
      end
    end
  end

  // op sequencer: one channel-state op per cycle, sample ops gated by output queue room
  always_comb begin
    case (job_kind)
      JOB_HDR:  last_step = 2'd0;
      JOB_MONO: last_step = 2'd1;
      JOB_PAIR: last_step = 2'd3;
      default:  last_step = 2'd0;
    endcase
  end

  assign needs_out = (job_kind != JOB_HDR);
  assign credit_ok = ({1'b0, fifo_cnt} + (FIFO_CW + 1)'(res_valid))
                     < (FIFO_CW + 1)'(FIFO_DEPTH);
  assign issue     = job_valid & (~needs_out | credit_ok);
  assign job_done  = issue & (job_step == last_step);
  assign s_tready  = ~job_valid | job_done;

  // pair order: left low, right low, left high, right high
  assign src_byte = (job_kind == JOB_PAIR && !job_step[0]) ? lb_rd : job_byte;
  assign half     = (job_kind == JOB_PAIR) ? job_step[1] : job_step[0];

  always_comb begin
    op.valid    = issue;
    op.hdr      = (job_kind == JOB_HDR);
    op.chan     = (job_kind == JOB_HDR) ? job_chan
                : ((job_kind == JOB_PAIR) ? job_step[0] : 1'b0);
    op.code     = half ? src_byte[7:4] : src_byte[3:0];
    op.last     = (job_step == last_step);
    op.hdr_pred = job_pred;
    op.hdr_idx  = job_idx;
  end

  ima4dec_chan_unit u_chan (
    .clk       (clk),
    .rst       (rst),
    .op_in     (op),
    .res       (res),
    .res_valid (res_valid)
  );

  ima4dec_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (m_tready),
    .head      (head),
    .not_empty (m_tvalid),
    .cnt       (fifo_cnt)
  );

  assign m_tdata = head.sample;
  assign m_tuser = head.chan;
  assign m_tlast = head.last;

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> fifo_cnt < FIFO_CW'(FIFO_DEPTH))
    else $error("output queue overflow");

  // right-channel samples only arise in stereo mode
  a_right_only_stereo: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> stereo_mode)
    else $error("right channel sample in mono mode");

  // a finished job leaves the slot empty or holds a fresh job at its first step
  a_job_restart: assert property (@(posedge clk) disable iff (rst)
    job_done |=> (!job_valid || job_step == 2'd0))
    else $error("job step not restarted");

endmodule
